// File: rtl/cstm_pkg.sv
// Package with the constants, codes and beat types shared by the call stack timing monitor.
`timescale 1ns / 1ps

package cstm_pkg;

	// Number of frames the stack holds; deeper frames are counted but not stored.
	localparam int STACK_DEPTH = 64;
	localparam int STACK_AW    = $clog2(STACK_DEPTH);

	// Width wide enough to compare the 8-bit depth counter against the capacity.
	localparam int CMP_W = ((STACK_AW > 8) ? STACK_AW : 8) + 1;

	localparam int TIME_W  = 27;
	localparam int DEPTH_W = 8;
	localparam int ADDR_W  = 64;

	// Timestamps wrap every 100 seconds.
	localparam logic [TIME_W:0] WRAP_US = (TIME_W + 1)'(100 * 1000000);

	localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

	// Event opcodes.
	localparam logic OP_CALL = 1'b0;
	localparam logic OP_RET  = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_LOST      = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	// Configuration register indexes.
	localparam int        PADDR_W = 5;
	localparam logic [2:0] REG_RECORD_ENABLE = 3'd0;
	localparam logic [2:0] REG_MIN_COST      = 3'd1;
	localparam logic [2:0] REG_MAX_DEPTH     = 3'd2;
	localparam logic [2:0] REG_MAIN_ONLY     = 3'd3;
	localparam logic [2:0] REG_ON_MAIN       = 3'd4;

	localparam logic [TIME_W-1:0]  MIN_COST_RESET  = TIME_W'(1000);
	localparam logic [DEPTH_W-1:0] MAX_DEPTH_RESET = DEPTH_W'(3);

	typedef struct packed {
		logic              op;
		logic [63:0]       class_id;
		logic [63:0]       selector;
		logic [63:0]       return_addr;
		logic [TIME_W-1:0] time_us;
	} item_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  resume_addr;
		logic [1:0]         status;
		logic               record_valid;
		logic [63:0]        rec_class;
		logic [63:0]        rec_selector;
		logic [DEPTH_W-1:0] rec_depth;
		logic [TIME_W-1:0]  rec_cost;
	} result_t;

	typedef struct packed {
		logic [63:0]       class_id;
		logic [63:0]       selector;
		logic [63:0]       return_addr;
		logic [TIME_W-1:0] time_us;
	} frame_t;

endpackage

// File: rtl/call_stack_timing_monitor.sv
// Top level of the call stack timing monitor: frame stack, depth counter, timing and records.
`timescale 1ns / 1ps

// Channel   | Handshake              | Payload          | Direction
// ----------+------------------------+------------------+----------
// events    | start high, busy low   | item   (item_t)  | in
// results   | done, one cycle        | result (result_t)| out
// config    | APB psel/penable/pready| paddr/pwdata     | in, read back on prdata
//
// A beat is taken into the first-stage registers: the stack memory is read
// (or written) at the accepting edge, and the timing compare of a return is then
// captured in the result register. An event is accepted in every cycle, so busy
// stays low. A return always yields one result beat on done; a call yields none.
// Reset clears the depth counter and restores the register defaults; the stack
// contents are not cleared, since a frame is always pushed before it is popped.
// The receiver cannot stall: each result is shown for exactly one cycle.
module call_stack_timing_monitor (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  cstm_pkg::item_t               item,
	output logic                          done,
	output cstm_pkg::result_t             result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cstm_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import cstm_pkg::*;

	// Configuration registers.
	logic               record_enable_q;
	logic [TIME_W-1:0]  min_cost_q;
	logic [DEPTH_W-1:0] max_depth_q;
	logic               main_only_q;
	logic               on_main_q;

	logic       cfg_wr;
	logic [2:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_enable_q <= 1'b1;
			min_cost_q      <= MIN_COST_RESET;
			max_depth_q     <= MAX_DEPTH_RESET;
			main_only_q     <= 1'b1;
			on_main_q       <= 1'b1;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_RECORD_ENABLE: record_enable_q <= pwdata[0];
				REG_MIN_COST:      min_cost_q      <= pwdata[TIME_W-1:0];
				REG_MAX_DEPTH:     max_depth_q     <= pwdata[DEPTH_W-1:0];
				REG_MAIN_ONLY:     main_only_q     <= pwdata[0];
				REG_ON_MAIN:       on_main_q       <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (cfg_idx)
			REG_RECORD_ENABLE: prdata = 32'(record_enable_q);
			REG_MIN_COST:      prdata = 32'(min_cost_q);
			REG_MAX_DEPTH:     prdata = 32'(max_depth_q);
			REG_MAIN_ONLY:     prdata = 32'(main_only_q);
			REG_ON_MAIN:       prdata = 32'(on_main_q);
			default:           prdata = '0;
		endcase
	end

	// Event acceptance and stack control. The depth counter tracks frames pushed and
	// not popped, saturating at its maximum; only the lowest STACK_DEPTH are stored.
	logic               accept;
	logic               push;
	logic               pop;
	logic [DEPTH_W-1:0] depth_q;
	logic [DEPTH_W-1:0] pop_idx;
	logic               stored;
	logic               pop_stored;
	logic               underflow;

	assign busy      = 1'b0;
	assign accept    = start && !busy;
	assign underflow = (depth_q == '0);
	assign pop_idx   = depth_q - DEPTH_W'(1);
	assign stored    = CMP_W'(depth_q) < CMP_W'(STACK_DEPTH);
	assign pop_stored = CMP_W'(pop_idx) < CMP_W'(STACK_DEPTH);
	assign push      = accept && (item.op == OP_CALL) && stored;
	assign pop       = accept && (item.op == OP_RET) && !underflow && pop_stored;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (accept) begin
			if (item.op == OP_CALL) begin
				if (depth_q != DEPTH_MAX) begin
					depth_q <= depth_q + DEPTH_W'(1);
				end
			end else if (!underflow) begin
				depth_q <= pop_idx;
			end
		end
	end

	// Frame memory: written by a call, read by a return, read data registered.
	frame_t mem [STACK_DEPTH];
	frame_t rd_s1;
	frame_t wr_frame;

	assign wr_frame.class_id    = item.class_id;
	assign wr_frame.selector    = item.selector;
	assign wr_frame.return_addr = item.return_addr;
	assign wr_frame.time_us     = item.time_us;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[STACK_AW'(depth_q)] <= wr_frame;
		end
		if (pop) begin
			rd_s1 <= mem[STACK_AW'(pop_idx)];
		end
	end

	// First stage: what kind of return this was, and the data needed for timing.
	logic               ret_s1;
	logic [1:0]         status_s1;
	logic [DEPTH_W-1:0] idx_s1;
	logic [TIME_W-1:0]  now_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ret_s1 <= 1'b0;
		end else begin
			ret_s1 <= accept && (item.op == OP_RET);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (item.op == OP_RET)) begin
			idx_s1 <= pop_idx;
			now_s1 <= item.time_us;
			if (underflow) begin
				status_s1 <= ST_UNDERFLOW;
			end else if (!pop_stored) begin
				status_s1 <= ST_LOST;
			end else begin
				status_s1 <= ST_OK;
			end
		end
	end

	// Second stage: elapsed time with wrap correction and the record decision.
	logic              timing_on;
	logic [TIME_W:0]   cost_wide;
	logic [TIME_W-1:0] cost;
	logic              emit;
	result_t           res_d;

	assign timing_on = record_enable_q && (!main_only_q || on_main_q);

	always_comb begin
		if (now_s1 < rd_s1.time_us) begin
			cost_wide = {1'b0, now_s1} + WRAP_US - {1'b0, rd_s1.time_us};
		end else begin
			cost_wide = {1'b0, now_s1} - {1'b0, rd_s1.time_us};
		end
		cost = cost_wide[TIME_W-1:0];
		emit = (status_s1 == ST_OK) && timing_on && (cost > min_cost_q)
			&& (idx_s1 <= max_depth_q);

		res_d = '0;
		res_d.status = status_s1;
		if (status_s1 == ST_OK) begin
			res_d.resume_addr = rd_s1.return_addr;
		end
		if (emit) begin
			res_d.record_valid = 1'b1;
			res_d.rec_class    = rd_s1.class_id;
			res_d.rec_selector = rd_s1.selector;
			res_d.rec_depth    = idx_s1;
			res_d.rec_cost     = cost;
		end
	end

	logic    done_q;
	result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ret_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ret_s1) begin
			result_q <= res_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// A result beat always traces back to a return registered in the first stage.
	a_done_from_return: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(ret_s1))
		else $error("result beat without a preceding return");

	// An underflow or lost frame never carries an address or a record.
	a_fault_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status != ST_OK)) |-> (result.resume_addr == '0 && !result.record_valid))
		else $error("faulted return carries data");

	// A return on an empty stack leaves the depth at zero.
	a_no_wrap_under: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.op == OP_RET && underflow) |=> (depth_q == '0))
		else $error("depth counter wrapped below zero");

	// Records respect the depth limit in force.
	a_rec_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.record_valid) |-> (result.rec_depth <= max_depth_q))
		else $error("record emitted beyond the depth limit");

endmodule

// File: tb/cstm_checker.sv
// Checker for the call stack timing monitor: predicts each result beat and compares it.
`timescale 1ns / 1ps

module cstm_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  cstm_pkg::item_t   item,
	input  logic              done,
	input  cstm_pkg::result_t result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [cstm_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output int                outstanding,
	output int                errors
);
	import cstm_pkg::*;

	// Shadow copy of the frame stack and the depth counter.
	logic [63:0]        saved_class [STACK_DEPTH];
	logic [63:0]        saved_selector [STACK_DEPTH];
	logic [63:0]        saved_return [STACK_DEPTH];
	logic [TIME_W-1:0]  saved_time [STACK_DEPTH];
	logic [DEPTH_W-1:0] depth;

	// Shadow copy of the configuration registers.
	logic               rec_en;
	logic [TIME_W-1:0]  cost_floor;
	logic [DEPTH_W-1:0] depth_limit;
	logic               main_only_q;
	logic               on_main_q;

	result_t            awaited_results[$];
	result_t            want;

	task automatic push_frame(input item_t ev);
		if (depth < STACK_DEPTH) begin
			saved_class[depth]    = ev.class_id;
			saved_selector[depth] = ev.selector;
			saved_return[depth]   = ev.return_addr;
			saved_time[depth]     = ev.time_us;
		end
		if (depth != DEPTH_MAX) begin
			depth = depth + 1'b1;
		end
	endtask

	// Pops the top frame and works out the result beat that the return produces.
	function automatic result_t retire_frame(input logic [TIME_W-1:0] now);
		result_t     r;
		int unsigned d;
		int unsigned n;
		int unsigned t;
		int unsigned cost;
		r = '0;
		if (depth == '0) begin
			r.status = ST_UNDERFLOW;
			return r;
		end
		depth = depth - 1'b1;
		d = depth;
		if (d >= STACK_DEPTH) begin
			r.status = ST_LOST;
			return r;
		end
		r.status = ST_OK;
		r.resume_addr = saved_return[d];
		if (rec_en && (!main_only_q || on_main_q)) begin
			n = now;
			t = saved_time[d];
			cost = (n < t) ? (n + int'(WRAP_US) - t) : (n - t);
			cost = cost & ((1 << TIME_W) - 1);
			if (cost > cost_floor && d <= depth_limit) begin
				r.record_valid = 1'b1;
				r.rec_class    = saved_class[d];
				r.rec_selector = saved_selector[d];
				r.rec_depth    = DEPTH_W'(d);
				r.rec_cost     = TIME_W'(cost);
			end
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] exp_v, input logic [63:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth       = '0;
			rec_en      = 1'b1;
			cost_floor  = MIN_COST_RESET;
			depth_limit = MAX_DEPTH_RESET;
			main_only_q = 1'b1;
			on_main_q   = 1'b1;
			awaited_results.delete();
			outstanding = 0;
		end else begin
			if (done === 1'b1) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: result beat with none expected, expected none, actual %h",
						$time, result);
					errors++;
				end else begin
					want = awaited_results.pop_front();
					check_field("resume_addr", want.resume_addr, result.resume_addr);
					check_field("status", want.status, result.status);
					check_field("record_valid", want.record_valid, result.record_valid);
					check_field("rec_class", want.rec_class, result.rec_class);
					check_field("rec_selector", want.rec_selector, result.rec_selector);
					check_field("rec_depth", want.rec_depth, result.rec_depth);
					check_field("rec_cost", want.rec_cost, result.rec_cost);
				end
			end else if (done !== 1'b0) begin
				$display("%0t: done unknown, expected %b, actual %b", $time, 1'b0, done);
				errors++;
			end

			if (start && !busy) begin
				if (item.op == OP_CALL) begin
					push_frame(item);
				end else begin
					awaited_results.push_back(retire_frame(item.time_us));
				end
			end

			if (psel && penable && pwrite && pready) begin
				case (paddr[PADDR_W-1:2])
					REG_RECORD_ENABLE: rec_en      = pwdata[0];
					REG_MIN_COST:      cost_floor  = pwdata[TIME_W-1:0];
					REG_MAX_DEPTH:     depth_limit = pwdata[DEPTH_W-1:0];
					REG_MAIN_ONLY:     main_only_q = pwdata[0];
					REG_ON_MAIN:       on_main_q   = pwdata[0];
					default: ;
				endcase
			end

			outstanding = awaited_results.size();
		end
	end

endmodule

// File: tb/call_stack_timing_monitor_tb.sv
// Testbench top for the call stack timing monitor: clock, reset, event and register stimulus.
`timescale 1ns / 1ps

module call_stack_timing_monitor_tb;
	import cstm_pkg::*;

	// The longest quiet stretch in a correct run is a sender gap or the settle time before
	// a register write; the watchdog allows far more than that.
	localparam int IDLE_LIMIT = 500;
	localparam int unsigned WRAP = 100000000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	item_t       item;
	logic        done;
	result_t     result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int          outstanding;
	int          errors;

	// Beats left in the current burst, the stack depth the generator believes in, and a
	// free-running microsecond clock from which timestamps are drawn.
	int          burst_left;
	int          gen_depth;
	int unsigned stamp_clock;

	always #1 clk = ~clk;

	call_stack_timing_monitor dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	cstm_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.item        (item),
		.done        (done),
		.result      (result),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.outstanding (outstanding),
		.errors      (errors)
	);

	// Payload words lean toward the all-zero and all-one patterns so that the extremes
	// show up often, and are otherwise fully random.
	function automatic logic [63:0] rand_word();
		int pick;
		pick = $urandom_range(0, 7);
		if (pick == 0) begin
			return '0;
		end
		if (pick == 1) begin
			return '1;
		end
		return {$urandom, $urandom};
	endfunction

	// Advances the microsecond clock by a random step. Now and then it jumps far ahead so
	// that the modulo-100-second wrap lands between a call and its return, and now and
	// then a raw 27-bit value is used, which may lie beyond the wrap point.
	function automatic logic [TIME_W-1:0] next_stamp(input int span);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 2) begin
			stamp_clock = (stamp_clock + $urandom_range(1, WRAP - 1)) % WRAP;
		end else begin
			stamp_clock = (stamp_clock + $urandom_range(0, span)) % WRAP;
		end
		if (pick >= 96) begin
			return TIME_W'($urandom);
		end
		return TIME_W'(stamp_clock);
	endfunction

	function automatic item_t make_event(input logic op, input logic [TIME_W-1:0] stamp);
		item_t ev;
		ev.op          = op;
		ev.class_id    = rand_word();
		ev.selector    = rand_word();
		ev.return_addr = rand_word();
		ev.time_us     = stamp;
		return ev;
	endfunction

	// Drives one event beat, entered and left at a falling edge. Beats go out in bursts;
	// between bursts start drops low, and a long burst now and then gives stretches with
	// no idling at all. start is only ever lowered and raised again on different falling
	// edges.
	task automatic send_event(input item_t ev);
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
		end
		start <= 1'b1;
		item <= ev;
		burst_left--;
		do @(posedge clk); while (busy !== 1'b0);
		@(negedge clk);
	endtask

	task automatic send_one(input logic op, input int span);
		send_event(make_event(op, next_stamp(span)));
		if (op == OP_CALL) begin
			gen_depth++;
		end else if (gen_depth > 0) begin
			gen_depth--;
		end
	endtask

	// Lowers start and waits until every expected result beat has come back, then waits on
	// so that a call still in flight has settled too.
	task automatic quiesce();
		start <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// One register write: setup cycle, then access cycle, then psel drops for a cycle so
	// that a following write starts on a fresh falling edge.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(input logic en, input logic [31:0] floor_us,
		input logic [31:0] limit, input logic only_main, input logic on_main);
		quiesce();
		write_reg(REG_RECORD_ENABLE, {31'b0, en});
		write_reg(REG_MIN_COST, floor_us);
		write_reg(REG_MAX_DEPTH, limit);
		write_reg(REG_MAIN_ONLY, {31'b0, only_main});
		write_reg(REG_ON_MAIN, {31'b0, on_main});
	endtask

	// A stretch of well-nested call and return traffic. The stack climbs toward nest with
	// the given call bias, a return on an empty stack slips in now and then as noise, and
	// the stack is drained at the end so that the next setting starts from empty.
	task automatic run_phase(input int n, input int nest, input int call_pct, input int span);
		logic op;
		for (int i = 0; i < n; i++) begin
			if (gen_depth == 0) begin
				op = ($urandom_range(0, 99) >= 6) ? OP_CALL : OP_RET;
			end else if (gen_depth >= nest) begin
				op = OP_RET;
			end else begin
				op = ($urandom_range(0, 99) < call_pct) ? OP_CALL : OP_RET;
			end
			send_one(op, span);
		end
		while (gen_depth > 0) send_one(OP_RET, span);
	endtask

	// The watchdog ends the run when nothing has been accepted for too long: no event,
	// no result beat and no register write.
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done === 1'b1 || (psel && penable && pwrite && pready)) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		arst_n      = 1'b0;
		start       = 1'b0;
		item        = '0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		burst_left  = 0;
		gen_depth   = 0;
		stamp_clock = 0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part under the reset settings: threshold 1000, depth limit 3.
		// A return on an empty stack underflows.
		send_event(make_event(OP_RET, TIME_W'(0)));
		// Three frames: all-zero fields, all-one fields at the last microsecond before the
		// wrap, and random fields.
		send_event(item_t'{OP_CALL, 64'd0, 64'd0, 64'd0, TIME_W'(0)});
		send_event(item_t'{OP_CALL, '1, '1, '1, TIME_W'(WRAP - 1)});
		send_event(make_event(OP_CALL, TIME_W'(5)));
		// A cost exactly at the threshold gives no record.
		send_event(make_event(OP_RET, TIME_W'(1005)));
		// The timestamp wrapped: one microsecond past the threshold, so a record.
		send_event(make_event(OP_RET, TIME_W'(1000)));
		// A time beyond the wrap point is taken as it is and gives the largest cost.
		send_event(make_event(OP_RET, '1));
		// Underflow again, with every bit of the beat set.
		send_event(item_t'{OP_RET, '1, '1, '1, '1});
		// Five frames, then returns: the deepest is past the depth limit, the rest record.
		repeat (5) send_event(make_event(OP_CALL, TIME_W'(0)));
		repeat (5) send_event(make_event(OP_RET, TIME_W'(5000)));

		// Any cost above zero records, at any depth, with the thread filter open.
		configure(1'b1, 32'd0, 32'd255, 1'b0, 1'b0);
		run_phase(200, 8, 55, 20);

		// Threshold one below the wrap period and depth limit zero: only the out-of-range times can record.
		configure(1'b1, WRAP - 1, 32'd0, 1'b1, 1'b1);
		run_phase(80, 6, 55, 5000000);

		// Recording off, and the stack driven past its capacity so that frames are lost.
		configure(1'b0, 32'd100, 32'd255, 1'b0, 1'b1);
		run_phase(150, STACK_DEPTH + 6, 75, 200);

		// Recording on but the monitored thread is not main while only main counts.
		configure(1'b1, 32'd10, 32'd255, 1'b1, 1'b0);
		run_phase(60, 6, 55, 100);

		// Mid settings with ordinary nesting.
		configure(1'b1, 32'd500, 32'd5, 1'b0, 1'b1);
		run_phase(200, 10, 55, 300);

		// Deep run: the depth counter saturates, so the last returns underflow. Writes to
		// the addresses past the last register must change nothing.
		configure(1'b1, 32'd200, 32'd100, 1'b1, 1'b1);
		for (int k = int'(REG_ON_MAIN) + 1; k < 8; k++) begin
			write_reg(3'(k), '1);
		end
		run_phase(300, 262, 95, 50);

		// Register values wider than the fields are cut to their widths.
		quiesce();
		write_reg(REG_RECORD_ENABLE, '1);
		write_reg(REG_MIN_COST, '1);
		write_reg(REG_MAX_DEPTH, '1);
		run_phase(60, 8, 55, 1000);

		// Back to the reset settings.
		configure(1'b1, 32'd1000, 32'd3, 1'b1, 1'b1);
		run_phase(150, 8, 55, 800);

		quiesce();
		if (errors == 0 && outstanding == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/cstm_pkg.sv
rtl/call_stack_timing_monitor.sv
tb/cstm_checker.sv
tb/call_stack_timing_monitor_tb.sv
